FILE: src/tcsp_pkg.sv
// package for the tls client hello sni parser
// holds parse phases, protocol constants and the action type
// between the parser front and the result back; no dependencies
package tcsp_pkg;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_TYPE,
    PH_MAJ,
    PH_MIN,
    PH_RLEN_HI,
    PH_RLEN_LO,
    PH_HS_TYPE,
    PH_SKIP_HS,
    PH_SID_LEN,
    PH_SKIP_SID,
    PH_CS_HI,
    PH_CS_LO,
    PH_SKIP_CS,
    PH_COMP_LEN,
    PH_SKIP_COMP,
    PH_EXT_TOT_HI,
    PH_EXT_TOT_LO,
    PH_EXT_T0,
    PH_EXT_T1,
    PH_EXT_L0,
    PH_EXT_L1,
    PH_SKIP_EXT,
    PH_SNI_L0,
    PH_SNI_L1,
    PH_SNI_TYPE,
    PH_HOST_HI,
    PH_HOST_LO,
    PH_HOST,
    PH_DONE
  } tcsp_phase_e;

  localparam logic [7:0]  REC_HANDSHAKE   = 8'd22;
  localparam logic [7:0]  VER_MAJOR       = 8'h03;
  localparam logic [7:0]  VER_MINOR_MAX   = 8'h04;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
  localparam logic [15:0] HS_SKIP         = 16'd37;
  localparam logic [15:0] SNI_EXT_TYPE    = 16'd0;
  localparam logic [7:0]  SNI_HOSTNAME    = 8'd0;
  localparam logic [15:0] SNI_HDR_LEN     = 16'd5;
  localparam logic [15:0] REC_HDR_LEN     = 16'd5;
  localparam logic [15:0] MIN_RECORD_LEN  = 16'd6;
  localparam logic [15:0] EXT_HDR_LEN     = 16'd4;

  localparam logic KIND_HOST    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // one parsed byte's worth of results: an optional hostname byte,
  // then an optional end-of-packet verdict
  typedef struct packed {
    logic        host_vld;
    logic [7:0]  host_byte;
    logic        verdict_vld;
    logic        found;
    logic [15:0] host_length;
  } tcsp_act_t;

endpackage

FILE: src/tcsp_if.sv
// valid/ready channel interfaces for the sni parser
// depends on nothing; payload widths are fixed by the byte and result formats
interface tcsp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [15:0] packet_length;
  logic        last_byte;

  modport source (output valid, output payload_byte, output packet_length,
                  output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input packet_length,
                  input last_byte, output ready);
endinterface

interface tcsp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  host_byte;
  logic        found;
  logic [15:0] host_length;
  logic        last;

  modport source (output valid, output kind, output host_byte, output found,
                  output host_length, output last, input ready);
  modport sink   (input valid, input kind, input host_byte, input found,
                  input host_length, input last, output ready);
endinterface

FILE: src/tcsp_front.sv
// parser front (uses tcsp_pkg): walks the record, handshake and extension
// headers one byte per cycle of fire_i; pushes hostname and verdict actions
module tcsp_front import tcsp_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_vld_i,
  input  logic [7:0]        byte_i,
  input  logic [15:0]       plen_i,
  input  logic              last_i,
  input  logic              fire_i,
  output logic              push_o,
  output tcsp_act_t         act_o
);

  localparam int LB = LENGTH_BITS;
  localparam int PW = (LB > 16) ? LB : 16;
  localparam int SW = PW + 1;

  tcsp_phase_e    phase_q, phase_d, ph_e, ph_nx;
  logic [LB-1:0]  pos_q, pos_d, pos_e, pos_n;
  logic [LB-1:0]  len_q, len_d, len_e, len_sat;
  logic [15:0]    skip_q, skip_d;
  logic [7:0]     acc_q, acc_d;
  logic [LB-1:0]  ext_end_q, ext_end_d;
  logic [15:0]    ext_len_q, ext_len_d;
  logic           sni_q, sni_d;
  logic [15:0]    host_rem_q, host_rem_d;
  logic [15:0]    host_cnt_q, host_cnt_d;
  logic           found_q, found_d, found_e, found_nx;
  logic           emit;
  logic [PW-1:0]  plen_w;
  logic [15:0]    word;
  logic [SW-1:0]  ext_sum, ext_chk;
  logic [16:0]    host_chk;
  logic [15:0]    skip_m1, host_m1;

  assign plen_w  = PW'(plen_i);
  assign len_sat = (plen_w > PW'({LB{1'b1}})) ? {LB{1'b1}} : plen_w[LB-1:0];

  // first byte of a packet starts from a cleared parser
  always_comb begin
    if (phase_q == PH_IDLE) begin
      ph_e    = PH_TYPE;
      pos_e   = '0;
      len_e   = len_sat;
      found_e = 1'b0;
    end else begin
      ph_e    = phase_q;
      pos_e   = pos_q;
      len_e   = len_q;
      found_e = found_q;
    end
  end

  assign pos_n    = pos_e + LB'(1);
  assign word     = {acc_q, byte_i};
  assign ext_sum  = SW'(pos_n) + SW'(word);
  assign ext_chk  = SW'(pos_n) + SW'(word);
  assign host_chk = 17'(word) + 17'(SNI_HDR_LEN);
  assign skip_m1  = skip_q - 16'd1;
  assign host_m1  = host_rem_q - 16'd1;

  // next state and datapath
  always_comb begin
    logic [LB-1:0] end_v;
    end_v      = '0;
    ph_nx      = ph_e;
    pos_d      = pos_e;
    skip_d     = skip_q;
    acc_d      = acc_q;
    ext_end_d  = ext_end_q;
    ext_len_d  = ext_len_q;
    sni_d      = sni_q;
    host_rem_d = host_rem_q;
    host_cnt_d = host_cnt_q;
    found_nx   = found_e;
    emit       = 1'b0;
    if (ph_e == PH_DONE) begin
      ph_nx = PH_DONE;
    end else if (pos_e >= len_e) begin
      ph_nx = PH_DONE;
    end else begin
      pos_d = pos_n;
      unique case (ph_e)
        PH_TYPE: begin
          ph_nx = (PW'(len_e) < PW'(MIN_RECORD_LEN) || byte_i != REC_HANDSHAKE)
                  ? PH_DONE : PH_MAJ;
        end
        PH_MAJ: ph_nx = (byte_i != VER_MAJOR) ? PH_DONE : PH_MIN;
        PH_MIN: ph_nx = (byte_i > VER_MINOR_MAX) ? PH_DONE : PH_RLEN_HI;
        PH_RLEN_HI: begin
          acc_d = byte_i;
          ph_nx = PH_RLEN_LO;
        end
        PH_RLEN_LO: begin
          ph_nx = (SW'(word) > SW'(len_e) - SW'(REC_HDR_LEN)) ? PH_DONE : PH_HS_TYPE;
        end
        PH_HS_TYPE: begin
          skip_d = HS_SKIP;
          ph_nx  = (byte_i != HS_CLIENT_HELLO) ? PH_DONE : PH_SKIP_HS;
        end
        PH_SKIP_HS: begin
          skip_d = skip_m1;
          if (skip_m1 == '0) ph_nx = PH_SID_LEN;
        end
        PH_SID_LEN: begin
          skip_d = 16'(byte_i);
          ph_nx  = (byte_i == '0) ? PH_CS_HI : PH_SKIP_SID;
        end
        PH_SKIP_SID: begin
          skip_d = skip_m1;
          if (skip_m1 == '0) ph_nx = PH_CS_HI;
        end
        PH_CS_HI: begin
          acc_d = byte_i;
          ph_nx = PH_CS_LO;
        end
        PH_CS_LO: begin
          skip_d = word;
          ph_nx  = (word == '0) ? PH_COMP_LEN : PH_SKIP_CS;
        end
        PH_SKIP_CS: begin
          skip_d = skip_m1;
          if (skip_m1 == '0) ph_nx = PH_COMP_LEN;
        end
        PH_COMP_LEN: begin
          skip_d = 16'(byte_i);
          ph_nx  = (byte_i == '0) ? PH_EXT_TOT_HI : PH_SKIP_COMP;
        end
        PH_SKIP_COMP: begin
          skip_d = skip_m1;
          if (skip_m1 == '0) ph_nx = PH_EXT_TOT_HI;
        end
        PH_EXT_TOT_HI: begin
          acc_d = byte_i;
          ph_nx = PH_EXT_TOT_LO;
        end
        PH_EXT_TOT_LO: begin
          end_v     = (ext_sum > SW'(len_e)) ? len_e : ext_sum[LB-1:0];
          ext_end_d = end_v;
          ph_nx     = (SW'(pos_n) + SW'(EXT_HDR_LEN) <= SW'(end_v)) ? PH_EXT_T0 : PH_DONE;
        end
        PH_EXT_T0: begin
          acc_d = byte_i;
          ph_nx = PH_EXT_T1;
        end
        PH_EXT_T1: begin
          sni_d = (word == SNI_EXT_TYPE);
          ph_nx = PH_EXT_L0;
        end
        PH_EXT_L0: begin
          acc_d = byte_i;
          ph_nx = PH_EXT_L1;
        end
        PH_EXT_L1: begin
          ext_len_d = word;
          if (ext_chk > SW'(ext_end_q)) begin
            ph_nx = PH_DONE;
          end else if (sni_q) begin
            ph_nx = (word < SNI_HDR_LEN) ? PH_DONE : PH_SNI_L0;
          end else if (word == '0) begin
            ph_nx = (SW'(pos_n) + SW'(EXT_HDR_LEN) <= SW'(ext_end_q))
                    ? PH_EXT_T0 : PH_DONE;
          end else begin
            skip_d = word;
            ph_nx  = PH_SKIP_EXT;
          end
        end
        PH_SKIP_EXT: begin
          skip_d = skip_m1;
          if (skip_m1 == '0) begin
            ph_nx = (SW'(pos_n) + SW'(EXT_HDR_LEN) <= SW'(ext_end_q))
                    ? PH_EXT_T0 : PH_DONE;
          end
        end
        PH_SNI_L0: ph_nx = PH_SNI_L1;
        PH_SNI_L1: ph_nx = PH_SNI_TYPE;
        PH_SNI_TYPE: ph_nx = (byte_i != SNI_HOSTNAME) ? PH_DONE : PH_HOST_HI;
        PH_HOST_HI: begin
          acc_d = byte_i;
          ph_nx = PH_HOST_LO;
        end
        PH_HOST_LO: begin
          if (word == '0 || host_chk > 17'(ext_len_q)) begin
            ph_nx = PH_DONE;
          end else begin
            host_rem_d = word;
            host_cnt_d = word;
            ph_nx      = PH_HOST;
          end
        end
        PH_HOST: begin
          emit       = 1'b1;
          host_rem_d = host_m1;
          if (host_m1 == '0) begin
            found_nx = 1'b1;
            ph_nx    = PH_DONE;
          end
        end
        default: ph_nx = PH_DONE;
      endcase
    end
    // the last byte closes the packet
    if (last_i) begin
      phase_d = PH_IDLE;
      found_d = 1'b0;
    end else begin
      phase_d = ph_nx;
      found_d = found_nx;
    end
    len_d = len_e;
  end

  // action pushed toward the result back
  always_comb begin
    act_o.host_vld    = emit;
    act_o.host_byte   = byte_i;
    act_o.verdict_vld = last_i;
    act_o.found       = found_nx;
    act_o.host_length = found_nx ? host_cnt_d : '0;
    push_o            = fire_i && byte_vld_i && (emit || last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      pos_q      <= '0;
      len_q      <= '0;
      skip_q     <= '0;
      acc_q      <= '0;
      ext_end_q  <= '0;
      ext_len_q  <= '0;
      sni_q      <= 1'b0;
      host_rem_q <= '0;
      host_cnt_q <= '0;
      found_q    <= 1'b0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      skip_q     <= skip_d;
      acc_q      <= acc_d;
      ext_end_q  <= ext_end_d;
      ext_len_q  <= ext_len_d;
      sni_q      <= sni_d;
      host_rem_q <= host_rem_d;
      host_cnt_q <= host_cnt_d;
      found_q    <= found_d;
    end
  end

endmodule

FILE: src/tcsp_queue.sv
// short action queue between the parser front and the result back
// uses tcsp_pkg for the action type
module tcsp_queue import tcsp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tcsp_act_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output tcsp_act_t head_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tcsp_act_t       mem_q [DEPTH];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    if (do_pop)  rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: src/tcsp_back.sv
// result back: turns queued actions into result requests, a hostname byte
// before a verdict, through an output register; uses tcsp_pkg and tcsp_out_if
module tcsp_back import tcsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  tcsp_act_t   head_i,
  output logic        pop_o,
  tcsp_out_if.source  out_o
);

  logic        out_vld_q, out_vld_d;
  logic        out_kind_q, out_kind_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_found_q, out_found_d;
  logic [15:0] out_len_q, out_len_d;
  logic        pend_q, pend_d;
  logic        pend_found_q, pend_found_d;
  logic [15:0] pend_len_q, pend_len_d;
  logic        slot_free;

  assign slot_free = !out_vld_q || out_o.ready;

  always_comb begin
    out_vld_d    = out_vld_q;
    out_kind_d   = out_kind_q;
    out_byte_d   = out_byte_q;
    out_found_d  = out_found_q;
    out_len_d    = out_len_q;
    pend_d       = pend_q;
    pend_found_d = pend_found_q;
    pend_len_d   = pend_len_q;
    pop_o        = 1'b0;
    if (slot_free) begin
      out_vld_d = 1'b0;
      if (pend_q) begin
        // verdict held back behind its hostname byte
        out_vld_d   = 1'b1;
        out_kind_d  = KIND_VERDICT;
        out_byte_d  = '0;
        out_found_d = pend_found_q;
        out_len_d   = pend_len_q;
        pend_d      = 1'b0;
      end else if (!empty_i) begin
        pop_o     = 1'b1;
        out_vld_d = 1'b1;
        if (head_i.host_vld) begin
          out_kind_d   = KIND_HOST;
          out_byte_d   = head_i.host_byte;
          out_found_d  = 1'b0;
          out_len_d    = '0;
          pend_d       = head_i.verdict_vld;
          pend_found_d = head_i.found;
          pend_len_d   = head_i.host_length;
        end else begin
          out_kind_d  = KIND_VERDICT;
          out_byte_d  = '0;
          out_found_d = head_i.found;
          out_len_d   = head_i.host_length;
        end
      end
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.host_byte   = out_byte_q;
  assign out_o.found       = out_found_q;
  assign out_o.host_length = out_len_q;
  assign out_o.last        = (out_kind_q == KIND_VERDICT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q   <= out_kind_d;
    out_byte_q   <= out_byte_d;
    out_found_q  <= out_found_d;
    out_len_q    <= out_len_d;
    pend_found_q <= pend_found_d;
    pend_len_q   <= pend_len_d;
  end

endmodule

FILE: src/tls_client_hello_sni_parser.sv
// top level of the tls client hello sni parser
// depends on tcsp_pkg, tcsp_if, tcsp_front, tcsp_queue and tcsp_back
//
//   channel  dir  fields                                         request
//   in_i     in   payload_byte, packet_length, last_byte         one payload byte
//   out_o    out  kind, host_byte, found, host_length, last      hostname byte or verdict
//
// the parser front takes one byte per cycle; its phase and counter update is
// registered per accepted byte, so bytes stream back to back while the queue has room
// a byte that both ends a hostname and ends the packet gives two results,
// which the back sends one after the other through its output register
// rst_ni clears phase, queue pointers and output valid at once; no sweep
// a stalled output fills the QUEUE_DEPTH-entry queue, then in_i.ready drops
module tls_client_hello_sni_parser import tcsp_pkg::*; #(
  parameter int LENGTH_BITS = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcsp_in_if.sink    in_i,
  tcsp_out_if.source out_o
);

  logic      push, full, pop, empty, fire;
  tcsp_act_t act, head;

  assign in_i.ready = !full;
  assign fire       = in_i.valid && !full;

  tcsp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (in_i.valid),
    .byte_i     (in_i.payload_byte),
    .plen_i     (in_i.packet_length),
    .last_i     (in_i.last_byte),
    .fire_i     (fire),
    .push_o     (push),
    .act_o      (act)
  );

  tcsp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (act),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  tcsp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
